// ===== src/two_point_sensor_calibration_macros.svh =====
// Assertion macros for the checker file of the sensor calibration block.
// No dependencies; include with the bare file name.
`ifndef TWO_POINT_SENSOR_CALIBRATION_MACROS_SVH
`define TWO_POINT_SENSOR_CALIBRATION_MACROS_SVH

// Clocked assertion that is switched off while reset is held.
`define TPSC_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define TPSC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/tpsc_pkg.sv =====
// Package for the two-point sensor calibration block: widths, codes and shared types.
// No dependencies; imported by every module of the block.
package tpsc_pkg;

    localparam int ADDR_W     = 5;   // eight 32-bit registers at 4-byte spacing
    localparam int DATA_W     = 32;
    localparam int QBITS      = 16;  // quotient bits produced by the divider
    localparam int NUM_MAG_W  = 31;  // magnitude of the numerator
    localparam int DEN_MAG_W  = 17;  // magnitude of the denominator
    localparam int REM_W      = 17;  // partial remainder, below the denominator unless the quotient overflows

    localparam logic [QBITS-1:0] SAT_POS_MAG = 16'd32767;
    localparam logic [QBITS-1:0] SAT_NEG_MAG = 16'd32768;
    localparam logic signed [15:0] VAL_MAX   = 16'sh7FFF;
    localparam logic signed [15:0] VAL_MIN   = 16'sh8000;

    typedef enum logic [2:0] {
        REG_TEMP_P0  = 3'd0,
        REG_TEMP_P1  = 3'd1,
        REG_TEMP_C0  = 3'd2,
        REG_TEMP_C1  = 3'd3,
        REG_HUMID_P0 = 3'd4,
        REG_HUMID_P1 = 3'd5,
        REG_HUMID_C0 = 3'd6,
        REG_HUMID_C1 = 3'd7
    } t_reg_idx;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_READY = 2'd1,
        ST_EQUAL     = 2'd2,
        ST_SAT       = 2'd3
    } t_status;

    typedef enum logic {
        ACT_TEMP  = 1'b0,
        ACT_HUMID = 1'b1
    } t_action;

    typedef struct packed {
        logic [9:0]         temp_point0_x8;
        logic [9:0]         temp_point1_x8;
        logic signed [15:0] temp_count0;
        logic signed [15:0] temp_count1;
        logic [7:0]         humid_point0_x2;
        logic [7:0]         humid_point1_x2;
        logic signed [15:0] humid_count0;
        logic signed [15:0] humid_count1;
    } t_cal;

    // Control that travels down the pipeline beside each sample.
    typedef struct packed {
        logic valid;
        logic not_ready;
        logic equal_cnt;
        logic neg;
        logic ovf;
    } t_tag;

endpackage

// ===== src/tpsc_regs.sv =====
// Calibration register file behind the APB-style configuration port.
// Depends on tpsc_pkg.
module tpsc_regs
    import tpsc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output t_cal              o_cal
);

    t_cal     r_cal;
    t_reg_idx idx;
    logic     wr_en;

    assign pready = 1'b1;
    assign idx    = t_reg_idx'(paddr[ADDR_W-1:2]);
    assign wr_en  = psel & penable & pwrite;
    assign o_cal  = r_cal;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal <= '0;
        end else if (wr_en) begin
            case (idx)
                REG_TEMP_P0:  r_cal.temp_point0_x8  <= pwdata[9:0];
                REG_TEMP_P1:  r_cal.temp_point1_x8  <= pwdata[9:0];
                REG_TEMP_C0:  r_cal.temp_count0     <= $signed(pwdata[15:0]);
                REG_TEMP_C1:  r_cal.temp_count1     <= $signed(pwdata[15:0]);
                REG_HUMID_P0: r_cal.humid_point0_x2 <= pwdata[7:0];
                REG_HUMID_P1: r_cal.humid_point1_x2 <= pwdata[7:0];
                REG_HUMID_C0: r_cal.humid_count0    <= $signed(pwdata[15:0]);
                REG_HUMID_C1: r_cal.humid_count1    <= $signed(pwdata[15:0]);
                default:      r_cal                 <= r_cal;
            endcase
        end
    end

    always_comb begin
        case (idx)
            REG_TEMP_P0:  prdata = {22'd0, r_cal.temp_point0_x8};
            REG_TEMP_P1:  prdata = {22'd0, r_cal.temp_point1_x8};
            REG_TEMP_C0:  prdata = {16'd0, r_cal.temp_count0};
            REG_TEMP_C1:  prdata = {16'd0, r_cal.temp_count1};
            REG_HUMID_P0: prdata = {24'd0, r_cal.humid_point0_x2};
            REG_HUMID_P1: prdata = {24'd0, r_cal.humid_point1_x2};
            REG_HUMID_C0: prdata = {16'd0, r_cal.humid_count0};
            REG_HUMID_C1: prdata = {16'd0, r_cal.humid_count1};
            default:      prdata = '0;
        endcase
    end

endmodule

// ===== src/tpsc_prep.sv =====
// Front of the pipeline: point select, differences, products, numerator and magnitudes.
// Depends on tpsc_pkg; feeds tpsc_div.
module tpsc_prep
    import tpsc_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_accept,
    input  logic                 i_action,
    input  logic                 i_data_ready,
    input  logic signed [15:0]   i_raw_count,
    input  t_cal                 i_cal,
    output t_tag                 o_tag,
    output logic [REM_W-1:0]     o_rem,
    output logic [QBITS-1:0]     o_low,
    output logic [DEN_MAG_W-1:0] o_den
);

    // Stage A: select the calibration pair and form the differences.
    logic [9:0]         sel_p0;
    logic [9:0]         sel_p1;
    logic signed [15:0] sel_c0;
    logic signed [15:0] sel_c1;
    t_tag               n_a_tag;
    t_tag               r_a_tag;
    logic               r_a_temp;
    logic signed [16:0] r_a_dr;
    logic signed [10:0] r_a_dp;
    logic signed [16:0] r_a_dc;
    logic [9:0]         r_a_p0;

    always_comb begin
        if (t_action'(i_action) == ACT_TEMP) begin
            sel_p0 = i_cal.temp_point0_x8;
            sel_p1 = i_cal.temp_point1_x8;
            sel_c0 = i_cal.temp_count0;
            sel_c1 = i_cal.temp_count1;
        end else begin
            sel_p0 = {2'b00, i_cal.humid_point0_x2};
            sel_p1 = {2'b00, i_cal.humid_point1_x2};
            sel_c0 = i_cal.humid_count0;
            sel_c1 = i_cal.humid_count1;
        end
        n_a_tag           = '0;
        n_a_tag.valid     = i_accept;
        n_a_tag.not_ready = ~i_data_ready;
        n_a_tag.equal_cnt = (sel_c0 == sel_c1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_tag <= '0;
        end else begin
            r_a_tag <= n_a_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_temp <= (t_action'(i_action) == ACT_TEMP);
        r_a_dr   <= $signed({i_raw_count[15], i_raw_count}) - $signed({sel_c0[15], sel_c0});
        r_a_dp   <= $signed({1'b0, sel_p1}) - $signed({1'b0, sel_p0});
        r_a_dc   <= $signed({sel_c1[15], sel_c1}) - $signed({sel_c0[15], sel_c0});
        r_a_p0   <= sel_p0;
    end

    // Stage B: the two products and the denominator.
    t_tag               r_b_tag;
    logic               r_b_temp;
    logic signed [27:0] r_b_prod1;
    logic signed [27:0] r_b_prod2;
    logic signed [17:0] r_b_den;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_tag <= '0;
        end else begin
            r_b_tag <= r_a_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        r_b_temp  <= r_a_temp;
        r_b_prod1 <= r_a_dr * r_a_dp;
        r_b_prod2 <= $signed({1'b0, r_a_p0}) * r_a_dc;
        r_b_den   <= r_a_temp ? $signed({r_a_dc[16], r_a_dc}) : $signed({r_a_dc, 1'b0});
    end

    // Stage C: numerator, scaled by eight for temperature.
    t_tag               r_c_tag;
    logic signed [28:0] sum_c;
    logic signed [31:0] r_c_num;
    logic signed [17:0] r_c_den;

    assign sum_c = $signed({r_b_prod1[27], r_b_prod1}) + $signed({r_b_prod2[27], r_b_prod2});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_tag <= '0;
        end else begin
            r_c_tag <= r_b_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        r_c_num <= r_b_temp ? $signed({sum_c, 3'b000}) : $signed({{3{sum_c[28]}}, sum_c});
        r_c_den <= r_b_den;
    end

    // Stage D: magnitudes, quotient sign and the early overflow test.
    logic [31:0]          num_abs;
    logic [17:0]          den_abs;
    logic [NUM_MAG_W-1:0] num_mag;
    logic [DEN_MAG_W-1:0] den_mag;
    t_tag                 n_d_tag;
    t_tag                 r_d_tag;
    logic [REM_W-1:0]     r_d_rem;
    logic [QBITS-1:0]     r_d_low;
    logic [DEN_MAG_W-1:0] r_d_den;

    always_comb begin
        num_abs = r_c_num[31] ? 32'(-r_c_num) : 32'(r_c_num);
        den_abs = r_c_den[17] ? 18'(-r_c_den) : 18'(r_c_den);
        num_mag = num_abs[NUM_MAG_W-1:0];
        den_mag = den_abs[DEN_MAG_W-1:0];
        n_d_tag     = r_c_tag;
        n_d_tag.neg = r_c_num[31] ^ r_c_den[17];
        // A quotient of 2^16 or more saturates whatever its sign.
        n_d_tag.ovf = {2'b00, num_mag} >= {den_mag, {QBITS{1'b0}}};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_tag <= '0;
        end else begin
            r_d_tag <= n_d_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        r_d_rem <= {{(REM_W-(NUM_MAG_W-QBITS)){1'b0}}, num_mag[NUM_MAG_W-1:QBITS]};
        r_d_low <= num_mag[QBITS-1:0];
        r_d_den <= den_mag;
    end

    assign o_tag = r_d_tag;
    assign o_rem = r_d_rem;
    assign o_low = r_d_low;
    assign o_den = r_d_den;

endmodule

// ===== src/tpsc_div.sv =====
// Pipelined restoring divider, one quotient bit per register stage.
// Depends on tpsc_pkg; fed by tpsc_prep, feeds tpsc_post.
module tpsc_div
    import tpsc_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_tag                 i_tag,
    input  logic [REM_W-1:0]     i_rem,
    input  logic [QBITS-1:0]     i_low,
    input  logic [DEN_MAG_W-1:0] i_den,
    output t_tag                 o_tag,
    output logic [QBITS-1:0]     o_quot
);

    t_tag                 r_tag  [QBITS];
    logic [REM_W-1:0]     r_rem  [QBITS];
    logic [QBITS-1:0]     r_low  [QBITS];
    logic [QBITS-1:0]     r_quot [QBITS];
    logic [DEN_MAG_W-1:0] r_den  [QBITS];

    for (genvar k = 0; k < QBITS; k++) begin : g_stage
        t_tag                 tag_in;
        logic [REM_W-1:0]     rem_in;
        logic [QBITS-1:0]     low_in;
        logic [QBITS-1:0]     quot_in;
        logic [DEN_MAG_W-1:0] den_in;
        logic [REM_W:0]       trial;
        logic [REM_W:0]       diff;
        logic                 take;

        if (k == 0) begin : g_first
            assign tag_in  = i_tag;
            assign rem_in  = i_rem;
            assign low_in  = i_low;
            assign quot_in = '0;
            assign den_in  = i_den;
        end else begin : g_next
            assign tag_in  = r_tag[k-1];
            assign rem_in  = r_rem[k-1];
            assign low_in  = r_low[k-1];
            assign quot_in = r_quot[k-1];
            assign den_in  = r_den[k-1];
        end

        assign trial = {rem_in, low_in[QBITS-1]};
        assign diff  = trial - {{(REM_W+1-DEN_MAG_W){1'b0}}, den_in};
        assign take  = trial >= {{(REM_W+1-DEN_MAG_W){1'b0}}, den_in};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_tag[k] <= '0;
            end else begin
                r_tag[k] <= tag_in;
            end
        end

        always_ff @(posedge i_clk) begin
            r_rem[k]  <= take ? diff[REM_W-1:0] : trial[REM_W-1:0];
            r_low[k]  <= {low_in[QBITS-2:0], 1'b0};
            r_quot[k] <= {quot_in[QBITS-2:0], take};
            r_den[k]  <= den_in;
        end
    end

    assign o_tag  = r_tag[QBITS-1];
    assign o_quot = r_quot[QBITS-1];

endmodule

// ===== src/tpsc_post.sv =====
// Output stage: sign, saturation, special cases and the result register.
// Depends on tpsc_pkg; fed by tpsc_div.
module tpsc_post
    import tpsc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_tag               i_tag,
    input  logic [QBITS-1:0]   i_quot,
    output logic               o_valid,
    output logic signed [15:0] o_value,
    output logic [1:0]         o_status
);

    logic               big;
    logic               sat;
    logic [QBITS-1:0]   neg_quot;
    logic signed [15:0] n_value;
    t_status            n_status;
    logic               r_valid;
    logic signed [15:0] r_value;
    t_status            r_status;

    always_comb begin
        big      = i_tag.neg ? (i_quot > SAT_NEG_MAG) : (i_quot > SAT_POS_MAG);
        sat      = i_tag.ovf | big;
        neg_quot = ~i_quot + 1'b1;
        if (i_tag.not_ready) begin
            n_value  = '0;
            n_status = ST_NOT_READY;
        end else if (i_tag.equal_cnt) begin
            n_value  = '0;
            n_status = ST_EQUAL;
        end else if (sat) begin
            n_value  = i_tag.neg ? VAL_MIN : VAL_MAX;
            n_status = ST_SAT;
        end else begin
            n_value  = i_tag.neg ? $signed(neg_quot) : $signed(i_quot);
            n_status = ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_tag.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value  <= n_value;
        r_status <= n_status;
    end

    assign o_valid  = r_valid;
    assign o_value  = r_value;
    assign o_status = r_status;

endmodule

// ===== src/two_point_sensor_calibration.sv =====
// Top level of the two-point sensor calibration block.
// Depends on tpsc_pkg, tpsc_regs, tpsc_prep, tpsc_div and tpsc_post.
//
// Usage. A raw signed 16-bit count is converted to a calibrated value by linear
// interpolation between two calibration points. Action 0 gives temperature in
// 1/64 degree, action 1 gives humidity in whole percent, truncated toward zero
// and saturated to 16 bits. The eight calibration registers are written through
// the APB-style port at byte address 4*i; pready is always high and a read
// returns the register contents.
// A sample beat is taken at every rising edge with start high and busy low.
// busy is low at all times outside reset, so one sample can enter each cycle.
// The result beat is shown on o_value and o_status with o_valid high for one
// cycle. Each sample passes through four front stages (select, multiply, add,
// magnitude), sixteen divider stages of one quotient bit each, and the output
// register. Throughput is one sample per cycle. The receiver cannot stall, so
// no result ever waits.
// Reset clears the calibration registers and the valid bits of the pipeline;
// samples in flight are dropped and busy stays high while reset is held.
module two_point_sensor_calibration
    import tpsc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [ADDR_W-1:0]  paddr,
    input  logic [DATA_W-1:0]  pwdata,
    output logic [DATA_W-1:0]  prdata,
    output logic               pready,
    input  logic               start,
    output logic               busy,
    input  logic               i_action,
    input  logic               i_data_ready,
    input  logic signed [15:0] i_raw_count,
    output logic               o_valid,
    output logic signed [15:0] o_value,
    output logic [1:0]         o_status
);

    t_cal                 cal;
    t_tag                 prep_tag;
    logic [REM_W-1:0]     prep_rem;
    logic [QBITS-1:0]     prep_low;
    logic [DEN_MAG_W-1:0] prep_den;
    t_tag                 div_tag;
    logic [QBITS-1:0]     div_quot;
    logic                 accept;

    // The pipeline never backs up, so the only time a beat is refused is reset.
    assign busy   = ~i_rst_n;
    assign accept = start & ~busy;

    tpsc_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cal   (cal)
    );

    // Front stages: point select and differences, products, numerator,
    // then magnitudes with the sign of the quotient and the overflow test.
    tpsc_prep u_prep (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_action     (i_action),
        .i_data_ready (i_data_ready),
        .i_raw_count  (i_raw_count),
        .i_cal        (cal),
        .o_tag        (prep_tag),
        .o_rem        (prep_rem),
        .o_low        (prep_low),
        .o_den        (prep_den)
    );

    // Unsigned division of the magnitudes; only sixteen quotient bits are
    // needed because larger quotients were already flagged as saturating.
    tpsc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tag   (prep_tag),
        .i_rem   (prep_rem),
        .i_low   (prep_low),
        .i_den   (prep_den),
        .o_tag   (div_tag),
        .o_quot  (div_quot)
    );

    // In priority: not-ready, equal-count, clamping, else the signed quotient.
    tpsc_post u_post (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_tag    (div_tag),
        .i_quot   (div_quot),
        .o_valid  (o_valid),
        .o_value  (o_value),
        .o_status (o_status)
    );

endmodule

// ===== src/tpsc_checker.sv =====
// Port-level checker for the sensor calibration block, bound to its top level.
// Depends on tpsc_pkg and two_point_sensor_calibration_macros.svh.
`include "two_point_sensor_calibration_macros.svh"

module tpsc_checker
    import tpsc_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               start,
    input logic               busy,
    input logic               i_data_ready,
    input logic               o_valid,
    input logic signed [15:0] o_value,
    input logic [1:0]         o_status
);

    // Every accepted beat comes out as a result beat, and nothing else does.
    `TPSC_ASSERT(a_latency, i_clk, i_rst_n, (start && !busy) |-> ##21 o_valid, "result beat missing")
    `TPSC_ASSERT(a_no_spurious, i_clk, i_rst_n, o_valid |-> $past(start && !busy, 21), "result beat without a sample")
    `TPSC_ASSERT(a_not_ready, i_clk, i_rst_n, (start && !busy && !i_data_ready) |-> ##21 (o_value == 16'sd0 && o_status == ST_NOT_READY), "stale sample not flagged")
    `TPSC_ASSERT_ALWAYS(a_sat_bound, i_clk, (o_valid && o_status == ST_SAT) |-> (o_value == VAL_MAX || o_value == VAL_MIN), "saturated value off the bounds")

endmodule

bind two_point_sensor_calibration tpsc_checker u_tpsc_checker (.*);

// ===== tb/two_point_sensor_calibration_tb.sv =====
// Self-checking bench for two_point_sensor_calibration: a directed table, then random beats.
// Depends on tpsc_pkg and the block's RTL; each result is checked against a hand-typed value
// or a local calibration calculation that follows the block's register settings.
module two_point_sensor_calibration_tb;
    import tpsc_pkg::*;

    // The settle time adds some slack to LATENCY.
    localparam int LATENCY         = 21;
    localparam int SETTLE          = LATENCY + 4;
    localparam int CYCLE_LIMIT     = 200000;
    localparam int RANDOM_PHASES   = 8;
    localparam int BEATS_PER_PHASE = 175;

    // One result beat as the block reports it.
    typedef struct packed {
        logic signed [15:0] value;
        t_status            status;
    } t_reading;

    // One row of the directed table. Rows with use_cal clear run on the reset calibration, where
    // all counts are equal. Rows with use_cal set run on DIRECTED_CAL below. Where has_want is
    // set, the expected reading is typed in by hand. Otherwise the bench calculates it.
    typedef struct {
        bit                 use_cal;
        t_action            act;
        bit                 ready;
        logic signed [15:0] raw;
        bit                 has_want;
        t_reading           want;
    } t_sample_case;

    // Temperature runs from 25 to 75 degrees over counts -1000 to 1000. Humidity runs from 20 to
    // 80 percent over counts 100 down to -100, which gives a negative denominator.
    localparam t_cal DIRECTED_CAL = '{10'd200, 10'd600, -16'sd1000, 16'sd1000,
                                      8'd40, 8'd160, 16'sd100, -16'sd100};

    t_sample_case directed_cases [19] = '{
        // Reset calibration. Equal counts give an error. A stale sample still reports not-ready,
        // because the not-ready check comes before the equal-count check.
        '{1'b0, ACT_TEMP,  1'b1, 16'sd0,      1'b1, '{16'sd0, ST_EQUAL}},
        '{1'b0, ACT_HUMID, 1'b1, 16'sh7FFF,   1'b1, '{16'sd0, ST_EQUAL}},
        '{1'b0, ACT_TEMP,  1'b0, 16'sh8000,   1'b1, '{16'sd0, ST_NOT_READY}},
        '{1'b0, ACT_HUMID, 1'b0, 16'sd12345,  1'b1, '{16'sd0, ST_NOT_READY}},
        // Directed calibration, temperature. Each calibration count maps onto its own point.
        // The extreme counts saturate in both directions.
        '{1'b1, ACT_TEMP,  1'b1, -16'sd1000,  1'b1, '{16'sd1600, ST_OK}},
        '{1'b1, ACT_TEMP,  1'b1, 16'sd1000,   1'b1, '{16'sd4800, ST_OK}},
        '{1'b1, ACT_TEMP,  1'b1, 16'sh7FFF,   1'b1, '{16'sh7FFF, ST_SAT}},
        '{1'b1, ACT_TEMP,  1'b1, 16'sh8000,   1'b1, '{16'sh8000, ST_SAT}},
        '{1'b1, ACT_TEMP,  1'b1, 16'sd0,      1'b0, '0},
        '{1'b1, ACT_TEMP,  1'b1, -16'sd1,     1'b0, '0},
        '{1'b1, ACT_TEMP,  1'b1, 16'sd333,    1'b0, '0},
        '{1'b1, ACT_TEMP,  1'b1, -16'sd2001,  1'b0, '0},  // small negative value, truncated to -1
        '{1'b1, ACT_TEMP,  1'b0, 16'sd1000,   1'b1, '{16'sd0, ST_NOT_READY}},
        // Directed calibration, humidity.
        '{1'b1, ACT_HUMID, 1'b1, 16'sd100,    1'b1, '{16'sd20, ST_OK}},
        '{1'b1, ACT_HUMID, 1'b1, -16'sd100,   1'b1, '{16'sd80, ST_OK}},
        '{1'b1, ACT_HUMID, 1'b1, 16'sh7FFF,   1'b0, '0},
        '{1'b1, ACT_HUMID, 1'b1, 16'sh8000,   1'b0, '0},
        '{1'b1, ACT_HUMID, 1'b1, 16'sd7,      1'b0, '0},
        '{1'b1, ACT_HUMID, 1'b0, -16'sd100,   1'b1, '{16'sd0, ST_NOT_READY}}
    };

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [ADDR_W-1:0]  paddr;
    logic [DATA_W-1:0]  pwdata;
    logic [DATA_W-1:0]  prdata;
    logic               pready;
    logic               start;
    logic               busy;
    logic               i_action;
    logic               i_data_ready;
    logic signed [15:0] i_raw_count;
    logic               o_valid;
    logic signed [15:0] o_value;
    logic [1:0]         o_status;

    // This copy of the calibration registers is updated from the data that is actually written.
    // So the masking of unused upper bits is checked as well.
    t_cal     cal_mirror = '0;
    t_reading expected_readings[$];
    int       mismatch_count = 0;
    int       cycle_count = 0;

    two_point_sensor_calibration dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .start        (start),
        .busy         (busy),
        .i_action     (i_action),
        .i_data_ready (i_data_ready),
        .i_raw_count  (i_raw_count),
        .o_valid      (o_valid),
        .o_value      (o_value),
        .o_status     (o_status)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Calculates the calibrated reading in exact 64-bit integer arithmetic. SystemVerilog
    // division already truncates toward zero, which is the rounding the block has to give.
    function automatic t_reading calibrate_reading(t_cal c, t_action act, bit ready,
                                                   logic signed [15:0] raw);
        t_reading r;
        longint   x, p0, p1, c0, c1, num, den, q;
        r.value  = '0;
        r.status = ST_OK;
        x = raw;
        if (!ready) begin
            r.status = ST_NOT_READY;
            return r;
        end
        if (act == ACT_TEMP) begin
            p0 = longint'(c.temp_point0_x8);
            p1 = longint'(c.temp_point1_x8);
            c0 = longint'($signed(c.temp_count0));
            c1 = longint'($signed(c.temp_count1));
        end else begin
            p0 = longint'(c.humid_point0_x2);
            p1 = longint'(c.humid_point1_x2);
            c0 = longint'($signed(c.humid_count0));
            c1 = longint'($signed(c.humid_count1));
        end
        if (c0 == c1) begin
            r.status = ST_EQUAL;
            return r;
        end
        // Temperature is scaled up by 8 to get 1/64 degree. Humidity is halved to get whole
        // percent. Both formulas use one division, so there is only one truncation.
        if (act == ACT_TEMP) begin
            num = (x - c0) * (p1 - p0) * 8 + p0 * 8 * (c1 - c0);
            den = c1 - c0;
        end else begin
            num = (x - c0) * (p1 - p0) + p0 * (c1 - c0);
            den = 2 * (c1 - c0);
        end
        q = num / den;
        if (q > 32767) begin
            q        = 32767;
            r.status = ST_SAT;
        end else if (q < -32768) begin
            q        = -32768;
            r.status = ST_SAT;
        end
        r.value = q[15:0];
        return r;
    endfunction

    // Two calibration counts of one kind. The kinds are: full span rising, full span falling,
    // equal counts, a span of a few counts only (which saturates easily), and random counts.
    function automatic void pick_counts(int kind, output logic signed [15:0] c0,
                                        output logic signed [15:0] c1);
        logic signed [15:0] delta;
        delta = 16'($urandom_range(1, 4));
        case (kind)
            0: begin
                c0 = 16'sh8000;
                c1 = 16'sh7FFF;
            end
            1: begin
                c0 = 16'sh7FFF;
                c1 = 16'sh8000;
            end
            2: begin
                c0 = 16'($urandom);
                c1 = c0;
            end
            3: begin
                c0 = 16'($urandom);
                c1 = ($urandom_range(0, 1) != 0) ? c0 + delta : c0 - delta;
            end
            default: begin
                c0 = 16'($urandom);
                c1 = 16'($urandom);
            end
        endcase
    endfunction

    // Makes a calibration for one random phase. Kinds 0 and 1 also put the calibration points
    // at their extremes, rising and falling.
    function automatic t_cal random_cal(int temp_kind, int humid_kind);
        t_cal               c;
        logic signed [15:0] a, b;
        pick_counts(temp_kind, a, b);
        c.temp_count0 = a;
        c.temp_count1 = b;
        pick_counts(humid_kind, a, b);
        c.humid_count0 = a;
        c.humid_count1 = b;
        case (temp_kind)
            0:       begin c.temp_point0_x8 = 10'd0;    c.temp_point1_x8 = 10'd1023; end
            1:       begin c.temp_point0_x8 = 10'd1023; c.temp_point1_x8 = 10'd0;    end
            default: begin
                c.temp_point0_x8 = 10'($urandom_range(0, 1023));
                c.temp_point1_x8 = 10'($urandom_range(0, 1023));
            end
        endcase
        case (humid_kind)
            0:       begin c.humid_point0_x2 = 8'd0;   c.humid_point1_x2 = 8'd255; end
            1:       begin c.humid_point0_x2 = 8'd255; c.humid_point1_x2 = 8'd0;   end
            default: begin
                c.humid_point0_x2 = 8'($urandom_range(0, 255));
                c.humid_point1_x2 = 8'($urandom_range(0, 255));
            end
        endcase
        return c;
    endfunction

    // Most raw counts fall in or just around the calibrated span, so that most results are
    // unsaturated. The rest are extremes and fully random values.
    function automatic logic signed [15:0] pick_raw(t_action act);
        longint c0, c1, lo, w, v;
        c0 = (act == ACT_TEMP) ? longint'($signed(cal_mirror.temp_count0))
                               : longint'($signed(cal_mirror.humid_count0));
        c1 = (act == ACT_TEMP) ? longint'($signed(cal_mirror.temp_count1))
                               : longint'($signed(cal_mirror.humid_count1));
        lo = (c0 < c1) ? c0 : c1;
        w  = ((c0 < c1) ? c1 - c0 : c0 - c1) + 1;
        case ($urandom_range(0, 9))
            0: begin
                case ($urandom_range(0, 3))
                    0:       v = -32768;
                    1:       v = 32767;
                    2:       v = 0;
                    default: v = -1;
                endcase
            end
            1, 2:    v = longint'($signed(16'($urandom)));
            default: v = lo - w / 4 + longint'($urandom_range(0, 32'(w + w / 2)));
        endcase
        if (v < -32768) v = -32768;
        if (v > 32767) v = 32767;
        return v[15:0];
    endfunction

    // An APB write: the setup cycle, then the access cycle. The register takes the data at the
    // edge where pready is seen high. psel is left high so that writes can follow each other
    // without a second assignment in the same time step. The caller lowers it.
    task automatic reg_write(t_reg_idx idx, logic [DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        case (idx)
            REG_TEMP_P0:  cal_mirror.temp_point0_x8  = data[9:0];
            REG_TEMP_P1:  cal_mirror.temp_point1_x8  = data[9:0];
            REG_TEMP_C0:  cal_mirror.temp_count0     = data[15:0];
            REG_TEMP_C1:  cal_mirror.temp_count1     = data[15:0];
            REG_HUMID_P0: cal_mirror.humid_point0_x2 = data[7:0];
            REG_HUMID_P1: cal_mirror.humid_point1_x2 = data[7:0];
            REG_HUMID_C0: cal_mirror.humid_count0    = data[15:0];
            REG_HUMID_C1: cal_mirror.humid_count1    = data[15:0];
            default: ;
        endcase
    endtask

    // Writes all eight registers. The bits above each register's width are filled with random
    // junk, which the block must ignore.
    task automatic write_cal(t_cal nc);
        logic [DATA_W-1:0] d;
        d = $urandom; d[9:0]  = nc.temp_point0_x8;  reg_write(REG_TEMP_P0, d);
        d = $urandom; d[9:0]  = nc.temp_point1_x8;  reg_write(REG_TEMP_P1, d);
        d = $urandom; d[15:0] = nc.temp_count0;     reg_write(REG_TEMP_C0, d);
        d = $urandom; d[15:0] = nc.temp_count1;     reg_write(REG_TEMP_C1, d);
        d = $urandom; d[7:0]  = nc.humid_point0_x2; reg_write(REG_HUMID_P0, d);
        d = $urandom; d[7:0]  = nc.humid_point1_x2; reg_write(REG_HUMID_P1, d);
        d = $urandom; d[15:0] = nc.humid_count0;    reg_write(REG_HUMID_C0, d);
        d = $urandom; d[15:0] = nc.humid_count1;    reg_write(REG_HUMID_C1, d);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    // Presents one sample beat and holds it until the block takes it. start is left high, so
    // that the next beat can follow at once. A pause or a drain is what lowers start.
    task automatic send_beat(t_action act, bit ready, logic signed [15:0] raw,
                             bit has_want, t_reading want);
        start        <= 1'b1;
        i_action     <= act;
        i_data_ready <= ready;
        i_raw_count  <= raw;
        do @(posedge i_clk); while (busy);
        if (has_want)
            expected_readings.push_back(want);
        else
            expected_readings.push_back(calibrate_reading(cal_mirror, act, ready, raw));
    endtask

    task automatic pause(int n);
        start <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    // Stops sending until every result still expected has arrived. It first waits on the clock,
    // so that start is never lowered and raised again in the same time step.
    task automatic wait_drained(bit settle);
        start <= 1'b0;
        do @(posedge i_clk); while (expected_readings.size() != 0);
        if (settle) repeat (SETTLE) @(posedge i_clk);
    endtask

    // Result checker. The receiver cannot hold results off, so every result beat with o_valid
    // high is taken and compared with the oldest expected reading.
    always @(posedge i_clk) begin
        t_reading want;
        if (i_rst_n && o_valid) begin
            if (expected_readings.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual value %0d status %0d",
                         $time, o_value, o_status);
                mismatch_count = mismatch_count + 1;
            end else begin
                want = expected_readings.pop_front();
                if (o_value !== want.value) begin
                    $display("%0t: value mismatch, expected %0d actual %0d",
                             $time, want.value, o_value);
                    mismatch_count = mismatch_count + 1;
                end
                if (o_status !== want.status) begin
                    $display("%0t: status mismatch, expected %0d actual %0d",
                             $time, want.status, o_status);
                    mismatch_count = mismatch_count + 1;
                end
            end
        end
    end

    // Guards against a hang: the slowest correct run stays far below this limit.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        bit      cal_loaded;
        int      sent;
        int      burst;
        t_action act;
        cal_loaded = 1'b0;
        i_rst_n      <= 1'b0;
        psel         <= 1'b0;
        penable      <= 1'b0;
        pwrite       <= 1'b0;
        paddr        <= '0;
        pwdata       <= '0;
        start        <= 1'b0;
        i_action     <= ACT_TEMP;
        i_data_ready <= 1'b0;
        i_raw_count  <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part. The first rows run on the reset calibration. Before the first row that
        // needs the directed calibration, the pipeline is drained and the registers are loaded.
        for (int i = 0; i < $size(directed_cases); i++) begin
            if (directed_cases[i].use_cal && !cal_loaded) begin
                wait_drained(1'b1);
                write_cal(DIRECTED_CAL);
                cal_loaded = 1'b1;
            end
            send_beat(directed_cases[i].act, directed_cases[i].ready, directed_cases[i].raw,
                      directed_cases[i].has_want, directed_cases[i].want);
            if ($urandom_range(0, 3) == 0) pause($urandom_range(1, 3));
        end

        // Random part. Each phase loads a new calibration while the block is idle. The first
        // five phases go through every kind of count pair at least once, including the extremes.
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            wait_drained(1'b1);
            if (ph < 5)
                write_cal(random_cal(ph, (ph + 3) % 5));
            else
                write_cal(random_cal($urandom_range(0, 4), $urandom_range(0, 4)));
            sent = 0;
            while (sent < BEATS_PER_PHASE) begin
                burst = $urandom_range(1, 40);
                for (int b = 0; b < burst && sent < BEATS_PER_PHASE; b++) begin
                    act = t_action'($urandom_range(0, 1));
                    send_beat(act, $urandom_range(0, 7) != 0, pick_raw(act), 1'b0, '0);
                    sent++;
                end
                // After a burst: no gap at all, a short gap, or now and then a full drain.
                case ($urandom_range(0, 9))
                    0, 1, 2: ;
                    3:       wait_drained(1'b0);
                    default: pause($urandom_range(1, 8));
                endcase
            end
        end

        wait_drained(1'b1);
        if (mismatch_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ===== two_point_sensor_calibration.f =====
+incdir+src
src/tpsc_pkg.sv
src/tpsc_regs.sv
src/tpsc_prep.sv
src/tpsc_div.sv
src/tpsc_post.sv
src/two_point_sensor_calibration.sv
src/tpsc_checker.sv
tb/two_point_sensor_calibration_tb.sv
